// ===== hw/rtl/wsit_pkg.sv =====
`default_nettype none

package wsit_pkg;

  localparam int INT_BITS   = 32;
  localparam int LABEL_BITS = 64;
  localparam int MAG_W      = INT_BITS - 1;
  localparam int LEN_W      = $clog2(LABEL_BITS + 1);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    CL_SP,
    CL_TAB,
    CL_LF,
    CL_END
  } cls_e;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE,
    ERR_BAD_SIGN,
    ERR_INCOMPLETE_INT,
    ERR_OVERFLOW,
    ERR_EMPTY_LABEL,
    ERR_INCOMPLETE_LABEL,
    ERR_LONG_LABEL,
    ERR_BAD_INSTR,
    ERR_INCOMPLETE_INSTR,
    ERR_NEGATIVE_PARAM
  } err_e;

  typedef enum logic [4:0] {
    OP_PUSH, OP_DUP, OP_SWAP, OP_DROP, OP_COPY, OP_SLIDE,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_STORE, OP_LOAD, OP_OUTC, OP_OUTI, OP_INC, OP_INI,
    OP_MARK, OP_CALL, OP_GOTO, OP_IFZR, OP_IFNG, OP_RET, OP_EXIT
  } op_e;

  typedef enum logic [4:0] {
    PS_START = 5'd0,
    PS_S     = 5'd1,
    PS_SL    = 5'd2,
    PS_ST    = 5'd3,
    PS_T     = 5'd4,
    PS_TS    = 5'd5,
    PS_TSS   = 5'd6,
    PS_TST   = 5'd7,
    PS_TT    = 5'd8,
    PS_TL    = 5'd9,
    PS_TLS   = 5'd10,
    PS_TLT   = 5'd11,
    PS_L     = 5'd12,
    PS_LS    = 5'd13,
    PS_LT    = 5'd14,
    PS_LL    = 5'd15,
    PS_SIGN  = 5'd16,
    PS_DIG   = 5'd17,
    PS_LBL0  = 5'd18,
    PS_LBL   = 5'd19
  } pst_e;

  typedef enum logic [2:0] {
    A_GO,
    A_EMIT,
    A_BAD,
    A_INT,
    A_LBL
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [4:0] val;
  } tree_ent_t;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam tree_ent_t T_BAD = '{A_BAD, 5'd0};

  // prefix tree, columns space, tab, line feed; end of input is handled apart
  localparam tree_ent_t TREE [16][4] = '{
    '{'{A_GO, PS_S},       '{A_GO, PS_T},       '{A_GO, PS_L},       T_BAD},
    '{'{A_INT, OP_PUSH},   '{A_GO, PS_ST},      '{A_GO, PS_SL},      T_BAD},
    '{'{A_EMIT, OP_DUP},   '{A_EMIT, OP_SWAP},  '{A_EMIT, OP_DROP},  T_BAD},
    '{'{A_INT, OP_COPY},   T_BAD,               '{A_INT, OP_SLIDE},  T_BAD},
    '{'{A_GO, PS_TS},      '{A_GO, PS_TT},      '{A_GO, PS_TL},      T_BAD},
    '{'{A_GO, PS_TSS},     '{A_GO, PS_TST},     T_BAD,               T_BAD},
    '{'{A_EMIT, OP_ADD},   '{A_EMIT, OP_SUB},   '{A_EMIT, OP_MUL},   T_BAD},
    '{'{A_EMIT, OP_DIV},   '{A_EMIT, OP_MOD},   T_BAD,               T_BAD},
    '{'{A_EMIT, OP_STORE}, '{A_EMIT, OP_LOAD},  T_BAD,               T_BAD},
    '{'{A_GO, PS_TLS},     '{A_GO, PS_TLT},     T_BAD,               T_BAD},
    '{'{A_EMIT, OP_OUTC},  '{A_EMIT, OP_OUTI},  T_BAD,               T_BAD},
    '{'{A_EMIT, OP_INC},   '{A_EMIT, OP_INI},   T_BAD,               T_BAD},
    '{'{A_GO, PS_LS},      '{A_GO, PS_LT},      '{A_GO, PS_LL},      T_BAD},
    '{'{A_LBL, OP_MARK},   '{A_LBL, OP_CALL},   '{A_LBL, OP_GOTO},   T_BAD},
    '{'{A_LBL, OP_IFZR},   '{A_LBL, OP_IFNG},   '{A_EMIT, OP_RET},   T_BAD},
    '{T_BAD,               T_BAD,               '{A_EMIT, OP_EXIT},  T_BAD}
  };

endpackage

`default_nettype wire

// ===== hw/rtl/wsit_front.sv =====
`default_nettype none

module wsit_front (
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      ch_i,
  input  wire logic            at_end_i,
  input  wire wsit_pkg::qstat_t q_stat_i,
  output wsit_pkg::qword_t     q_push_o
);
  import wsit_pkg::*;

  cls_e cls;
  logic keep;

  // classify byte, drop everything that is not whitespace
  always_comb begin
    cls  = CL_SP;
    keep = 1'b1;
    if (at_end_i) begin
      cls = CL_END;
    end else if (ch_i == CH_SPACE) begin
      cls = CL_SP;
    end else if (ch_i == CH_TAB) begin
      cls = CL_TAB;
    end else if (ch_i == CH_LF) begin
      cls = CL_LF;
    end else begin
      keep = 1'b0;
    end
  end

  assign in_stall_o     = q_stat_i.full;
  assign q_push_o.valid = in_valid_i && !q_stat_i.full && keep;
  assign q_push_o.cls   = cls;

endmodule

`default_nettype wire

// ===== hw/rtl/wsit_queue.sv =====
`default_nettype none

module wsit_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wsit_pkg::qword_t push_i,
  input  wire logic             pop_i,
  output wsit_pkg::cls_e        head_o,
  output wsit_pkg::qstat_t      stat_o
);
  import wsit_pkg::*;

  cls_e              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i.valid ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i.valid) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.cls;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/wsit_back.sv =====
`default_nettype none

module wsit_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire wsit_pkg::cls_e                   head_i,
  input  wire wsit_pkg::qstat_t                 q_stat_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            kind_o,
  output logic [4:0]                            opcode_o,
  output logic signed [wsit_pkg::INT_BITS-1:0]  argument_o,
  output logic [wsit_pkg::LABEL_BITS-1:0]       label_bits_o,
  output logic [wsit_pkg::LEN_W-1:0]            label_length_o,
  output logic [3:0]                            error_code_o
);
  import wsit_pkg::*;

  pst_e                  state_q, state_d;
  op_e                   pend_q, pend_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [LABEL_BITS-1:0] lsh_q, lsh_d;
  logic [LEN_W-1:0]      lcnt_q, lcnt_d;
  logic                  out_valid_q;

  tree_ent_t             ent;
  logic                  is_tab;
  logic                  done;
  logic                  emit;
  kind_e                 r_kind;
  logic [4:0]            r_op;
  logic [INT_BITS-1:0]   r_arg;
  logic [LABEL_BITS-1:0] r_lbits;
  logic [LEN_W-1:0]      r_llen;
  err_e                  r_err;
  logic [INT_BITS-1:0]   int_val;
  logic                  neg_nz;

  assign pop_o   = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign ent     = TREE[state_q[3:0]][head_i];
  assign is_tab  = (head_i == CL_TAB);
  assign int_val = neg_q ? INT_BITS'(-{1'b0, mag_q}) : {1'b0, mag_q};
  assign neg_nz  = neg_q && (mag_q != '0);

  // results and data registers
  always_comb begin
    pend_d  = pend_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    lsh_d   = lsh_q;
    lcnt_d  = lcnt_q;
    done    = 1'b0;
    emit    = 1'b0;
    r_kind  = KIND_TOKEN;
    r_op    = '0;
    r_arg   = '0;
    r_lbits = '0;
    r_llen  = '0;
    r_err   = ERR_NONE;
    if (pop_o) begin
      if (head_i == CL_END) begin
        done   = 1'b1;
        emit   = 1'b1;
        r_kind = KIND_ERR;
        unique case (state_q)
          PS_START:        r_kind = KIND_END;
          PS_SIGN:         r_err  = ERR_BAD_SIGN;
          PS_DIG:          r_err  = ERR_INCOMPLETE_INT;
          PS_LBL0, PS_LBL: r_err  = ERR_INCOMPLETE_LABEL;
          default:         r_err  = ERR_INCOMPLETE_INSTR;
        endcase
      end else begin
        unique case (state_q)
          PS_SIGN: begin
            if (head_i == CL_LF) begin
              done   = 1'b1;
              emit   = 1'b1;
              r_kind = KIND_ERR;
              r_err  = ERR_BAD_SIGN;
            end else begin
              neg_d = is_tab;
              mag_d = '0;
            end
          end
          PS_DIG: begin
            if (head_i == CL_LF) begin
              done = 1'b1;
              if ((pend_q == OP_COPY || pend_q == OP_SLIDE) && neg_nz) begin
                emit   = 1'b1;
                r_kind = KIND_ERR;
                r_err  = ERR_NEGATIVE_PARAM;
              end else if (!(pend_q == OP_SLIDE && mag_q == '0)) begin
                emit  = 1'b1;
                r_op  = pend_q;
                r_arg = int_val;
              end
            end else begin
              mag_d = {mag_q[MAG_W-2:0], is_tab};
              if (mag_q[MAG_W-1]) begin
                done   = 1'b1;
                emit   = 1'b1;
                r_kind = KIND_ERR;
                r_err  = ERR_OVERFLOW;
              end
            end
          end
          PS_LBL0: begin
            if (head_i == CL_LF) begin
              done   = 1'b1;
              emit   = 1'b1;
              r_kind = KIND_ERR;
              r_err  = ERR_EMPTY_LABEL;
            end else begin
              lsh_d  = LABEL_BITS'(is_tab);
              lcnt_d = LEN_W'(1);
            end
          end
          PS_LBL: begin
            if (head_i == CL_LF) begin
              done    = 1'b1;
              emit    = 1'b1;
              r_op    = pend_q;
              r_lbits = lsh_q;
              r_llen  = lcnt_q;
            end else if (lcnt_q >= LEN_W'(LABEL_BITS)) begin
              done   = 1'b1;
              emit   = 1'b1;
              r_kind = KIND_ERR;
              r_err  = ERR_LONG_LABEL;
            end else begin
              lsh_d  = lsh_q | (LABEL_BITS'(is_tab) << lcnt_q);
              lcnt_d = lcnt_q + 1'b1;
            end
          end
          default: begin
            unique case (ent.act)
              A_BAD: begin
                done   = 1'b1;
                emit   = 1'b1;
                r_kind = KIND_ERR;
                r_err  = ERR_BAD_INSTR;
              end
              A_EMIT: begin
                done = 1'b1;
                emit = 1'b1;
                r_op = ent.val;
              end
              A_INT: begin
                pend_d = op_e'(ent.val);
              end
              A_LBL: begin
                pend_d = op_e'(ent.val);
                lsh_d  = '0;
                lcnt_d = '0;
              end
              default: begin
              end
            endcase
          end
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (pop_o) begin
      if (done) begin
        state_d = PS_START;
      end else begin
        unique case (state_q)
          PS_SIGN: state_d = PS_DIG;
          PS_DIG:  state_d = PS_DIG;
          PS_LBL0: state_d = PS_LBL;
          PS_LBL:  state_d = PS_LBL;
          default: begin
            unique case (ent.act)
              A_INT:   state_d = PS_SIGN;
              A_LBL:   state_d = PS_LBL0;
              A_GO:    state_d = pst_e'(ent.val);
              default: state_d = PS_START;
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PS_START;
      pend_q      <= OP_PUSH;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      lsh_q       <= '0;
      lcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      lsh_q   <= lsh_d;
      lcnt_q  <= lcnt_d;
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_o         <= r_kind;
      opcode_o       <= r_op;
      argument_o     <= r_arg;
      label_bits_o   <= r_lbits;
      label_length_o <= r_llen;
      error_code_o   <= r_err;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/whitespace_instruction_tokenizer_core.sv =====
// the result word is registered when the parser takes the byte that completes it from the queue
// throughput: one byte per cycle; the parser pops one queued byte per unstalled cycle
// bytes other than space, tab and line feed are dropped on entry and take no queue slot
// a four-entry queue separates byte intake from the parser, which stalls only on output
// reset: asynchronous, active low; parser at instruction start, queue and output empty
`default_nettype none

module whitespace_instruction_tokenizer_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [7:0]                       ch_i,
  input  wire logic                             at_end_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            kind_o,
  output logic [4:0]                            opcode_o,
  output logic signed [wsit_pkg::INT_BITS-1:0]  argument_o,
  output logic [wsit_pkg::LABEL_BITS-1:0]       label_bits_o,
  output logic [wsit_pkg::LEN_W-1:0]            label_length_o,
  output logic [3:0]                            error_code_o
);
  import wsit_pkg::*;

  qword_t q_push;
  qstat_t q_stat;
  cls_e   q_head;
  logic   q_pop;

  wsit_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .at_end_i   (at_end_i),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push)
  );

  wsit_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  wsit_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_stat_i       (q_stat),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .opcode_o       (opcode_o),
    .argument_o     (argument_o),
    .label_bits_o   (label_bits_o),
    .label_length_o (label_length_o),
    .error_code_o   (error_code_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wsit_checker.sv =====
`default_nettype none

module wsit_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [1:0]                       kind_o,
  input wire logic [4:0]                       opcode_o,
  input wire logic signed [wsit_pkg::INT_BITS-1:0] argument_o,
  input wire logic [wsit_pkg::LABEL_BITS-1:0]  label_bits_o,
  input wire logic [wsit_pkg::LEN_W-1:0]       label_length_o,
  input wire logic [3:0]                       error_code_o
);
  import wsit_pkg::*;

  // stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(argument_o)
      && $stable(label_bits_o) && $stable(error_code_o))
    else $error("result word changed while stalled");

  // error words carry a code and nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERR |-> error_code_o != ERR_NONE && opcode_o == '0
      && argument_o == '0 && label_bits_o == '0 && label_length_o == '0)
    else $error("error word with stray fields");

  // end words are empty
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_END |-> error_code_o == ERR_NONE && opcode_o == '0
      && argument_o == '0 && label_bits_o == '0 && label_length_o == '0)
    else $error("end word with stray fields");

  // only flow control words carry a label
  a_label_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TOKEN && label_length_o != '0 |->
      (opcode_o == OP_MARK || opcode_o == OP_CALL || opcode_o == OP_GOTO
       || opcode_o == OP_IFZR || opcode_o == OP_IFNG) && argument_o == '0
      && error_code_o == ERR_NONE)
    else $error("label on a non flow control word");

endmodule

bind whitespace_instruction_tokenizer_core wsit_checker u_wsit_checker (.*);

`default_nettype wire
